// ----- design/sssp_pkg.sv -----
// Shared types, sizes and codes for the single-source shortest path core.
// Used by every module under design/; it depends on nothing else.
package sssp_pkg;

  localparam int MAX_NODES   = 256;
  localparam int MAX_EDGES   = 4096;
  localparam int WEIGHT_BITS = 16;

  // Widths of the command fields as they arrive on the port.
  localparam int ID_BITS     = 8;
  localparam int WFIELD_BITS = 16;

  localparam int NODE_BITS      = $clog2(MAX_NODES);
  localparam int SPAN_BITS      = $clog2(MAX_NODES + 1);
  localparam int EDGE_ADDR_BITS = $clog2(MAX_EDGES);
  localparam int COUNT_BITS     = $clog2(MAX_EDGES + 1);
  localparam int DIST_BITS      = 24;

  localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0] DIST_CAP = DIST_INF - DIST_BITS'(1);

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]             command;
    logic [ID_BITS-1:0]     edge_from;
    logic [ID_BITS-1:0]     edge_to;
    logic [WFIELD_BITS-1:0] edge_weight;
    logic [ID_BITS-1:0]     query_source;
    logic [ID_BITS-1:0]     query_destination;
  } request_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 reachable;
    logic                 edges_dropped;
  } response_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]   tail;
    logic [NODE_BITS-1:0]   head;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                      wr_en;
    logic [EDGE_ADDR_BITS-1:0] wr_addr;
    edge_t                     wr_data;
    logic [EDGE_ADDR_BITS-1:0] rd_addr;
  } edge_req_t;

  typedef struct packed {
    logic                 clear;
    logic                 wr_en;
    logic [NODE_BITS-1:0] wr_addr;
    logic [DIST_BITS-1:0] wr_data;
    logic [NODE_BITS-1:0] rd_addr;
    logic                 settle_en;
    logic [NODE_BITS-1:0] settle_addr;
  } dist_req_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] path_dist;
    logic                 settled;
  } dist_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RELAX,
    ST_FETCH,
    ST_REPLY
  } state_t;

endpackage

// ----- design/sssp_edge_store.sv -----
// Edge store: one synchronous memory of packed tail, head and weight entries.
// One write port and one read port with registered read data; uses sssp_pkg.
module sssp_edge_store (
  input  logic               clk,
  input  sssp_pkg::edge_req_t req,
  output sssp_pkg::edge_t     rd_data
);

  sssp_pkg::edge_t mem [sssp_pkg::MAX_EDGES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

// ----- design/sssp_dist_mem.sv -----
// Per-node distance memory with written and settled flags kept in flip-flops.
// An entry not written since the last clear reads as unreachable; uses sssp_pkg.
module sssp_dist_mem (
  input  logic                clk,
  input  logic                rst,
  input  sssp_pkg::dist_req_t req,
  output sssp_pkg::dist_rsp_t rsp
);

  logic [sssp_pkg::DIST_BITS-1:0] mem [sssp_pkg::MAX_NODES];
  logic [sssp_pkg::MAX_NODES-1:0] written;
  logic [sssp_pkg::MAX_NODES-1:0] settled;
  logic [sssp_pkg::MAX_NODES-1:0] wr_mark;
  logic [sssp_pkg::MAX_NODES-1:0] settle_mark;
  logic [sssp_pkg::DIST_BITS-1:0] rd_data;
  logic                           rd_written;
  logic                           rd_settled;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data    <= mem[req.rd_addr];
    rd_written <= written[req.rd_addr];
    rd_settled <= settled[req.rd_addr];
  end

  always_comb begin
    wr_mark     = '0;
    settle_mark = '0;
    if (req.wr_en) begin
      wr_mark[req.wr_addr] = 1'b1;
    end
    if (req.settle_en) begin
      settle_mark[req.settle_addr] = 1'b1;
    end
  end

  // A clear and the write of the source land in the same cycle, so the
  // write must win over the clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      settled <= '0;
    end else begin
      written <= (req.clear ? '0 : written) | wr_mark;
      settled <= (req.clear ? '0 : settled) | settle_mark;
    end
  end

  assign rsp.path_dist = rd_written ? rd_data : sssp_pkg::DIST_INF;
  assign rsp.settled   = rd_settled;

endmodule

// ----- design/sssp_engine.sv -----
// Command decoder and search sequencer: edge count, node span, drop flag,
// minimum scan and edge relaxation pipeline. Uses sssp_pkg; drives both memories.
module sssp_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  sssp_pkg::request_t  request,
  output logic                busy,
  output sssp_pkg::response_t response,
  output logic                done,
  output sssp_pkg::edge_req_t edge_req,
  input  sssp_pkg::edge_t     edge_rd,
  output sssp_pkg::dist_req_t dist_req,
  input  sssp_pkg::dist_rsp_t dist_rsp
);

  localparam int NB = sssp_pkg::NODE_BITS;
  localparam int SB = sssp_pkg::SPAN_BITS;
  localparam int CB = sssp_pkg::COUNT_BITS;
  localparam int EB = sssp_pkg::EDGE_ADDR_BITS;
  localparam int DB = sssp_pkg::DIST_BITS;
  localparam int WB = sssp_pkg::WEIGHT_BITS;

  sssp_pkg::state_t state, state_next;

  logic [CB-1:0] edge_total, edge_total_next;
  logic [SB-1:0] node_span, node_span_next;
  logic          drop_flag, drop_flag_next;

  logic [SB-1:0] span, span_next;
  logic [NB-1:0] dst, dst_next;
  logic [SB-1:0] scan_idx, scan_idx_next;
  logic          scan_v, scan_v_next;
  logic [NB-1:0] scan_idx_d, scan_idx_d_next;
  logic [NB-1:0] pick, pick_next;
  logic [DB-1:0] pick_d, pick_d_next;
  logic [CB-1:0] edge_idx, edge_idx_next;
  logic          e_v1, e_v1_next;
  logic          e_v2, e_v2_next;
  logic [NB-1:0] head_d, head_d_next;
  logic [WB-1:0] w_d, w_d_next;
  logic          fwd_v, fwd_v_next;
  logic [NB-1:0] fwd_addr, fwd_addr_next;
  logic [DB-1:0] fwd_val, fwd_val_next;

  sssp_pkg::response_t response_next;
  logic                done_next;

  logic          in_range;
  logic [SB-1:0] edge_top;
  logic [SB-1:0] query_span;
  logic          scan_issue;
  logic          edge_issue;
  logic [DB-1:0] cur_dist;
  logic [DB:0]   sum;
  logic [DB-1:0] new_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sssp_pkg::ST_IDLE;
      edge_total <= '0;
      node_span  <= '0;
      drop_flag  <= 1'b0;
      scan_v     <= 1'b0;
      e_v1       <= 1'b0;
      e_v2       <= 1'b0;
      fwd_v      <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      edge_total <= edge_total_next;
      node_span  <= node_span_next;
      drop_flag  <= drop_flag_next;
      scan_v     <= scan_v_next;
      e_v1       <= e_v1_next;
      e_v2       <= e_v2_next;
      fwd_v      <= fwd_v_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    span       <= span_next;
    dst        <= dst_next;
    scan_idx   <= scan_idx_next;
    scan_idx_d <= scan_idx_d_next;
    pick       <= pick_next;
    pick_d     <= pick_d_next;
    edge_idx   <= edge_idx_next;
    head_d     <= head_d_next;
    w_d        <= w_d_next;
    fwd_addr   <= fwd_addr_next;
    fwd_val    <= fwd_val_next;
    response   <= response_next;
  end

  always_comb begin
    in_range = (32'(request.edge_from) < sssp_pkg::MAX_NODES) &&
               (32'(request.edge_to) < sssp_pkg::MAX_NODES);
    edge_top = (request.edge_from > request.edge_to) ?
               SB'(request.edge_from) + SB'(1) : SB'(request.edge_to) + SB'(1);
    query_span = (node_span == '0) ? SB'(1) : node_span;
    scan_issue = scan_idx < span;
    edge_issue = edge_idx < edge_total;
    // The entry written by the previous beat is not yet in the read data.
    cur_dist = (fwd_v && fwd_addr == head_d) ? fwd_val : dist_rsp.path_dist;
    sum      = (DB + 1)'(pick_d) + (DB + 1)'(w_d);
    new_dist = (sum > (DB + 1)'(sssp_pkg::DIST_CAP)) ? sssp_pkg::DIST_CAP : sum[DB-1:0];

    state_next      = state;
    edge_total_next = edge_total;
    node_span_next  = node_span;
    drop_flag_next  = drop_flag;
    span_next       = span;
    dst_next        = dst;
    scan_idx_next   = scan_idx;
    scan_v_next     = 1'b0;
    scan_idx_d_next = scan_idx[NB-1:0];
    pick_next       = pick;
    pick_d_next     = pick_d;
    edge_idx_next   = edge_idx;
    e_v1_next       = 1'b0;
    e_v2_next       = 1'b0;
    head_d_next     = head_d;
    w_d_next        = w_d;
    fwd_v_next      = 1'b0;
    fwd_addr_next   = fwd_addr;
    fwd_val_next    = fwd_val;
    response_next   = response;
    done_next       = 1'b0;

    edge_req.wr_en          = 1'b0;
    edge_req.wr_addr        = edge_total[EB-1:0];
    edge_req.wr_data.tail   = NB'(request.edge_from);
    edge_req.wr_data.head   = NB'(request.edge_to);
    edge_req.wr_data.weight = WB'(request.edge_weight);
    edge_req.rd_addr        = edge_idx[EB-1:0];

    dist_req.clear       = 1'b0;
    dist_req.wr_en       = 1'b0;
    dist_req.wr_addr     = NB'(request.query_source);
    dist_req.wr_data     = '0;
    dist_req.rd_addr     = scan_idx[NB-1:0];
    dist_req.settle_en   = 1'b0;
    dist_req.settle_addr = pick;

    unique case (state)
      sssp_pkg::ST_IDLE: begin
        if (start) begin
          unique case (request.command)
            sssp_pkg::CMD_ADD: begin
              if (in_range) begin
                if (32'(edge_total) == sssp_pkg::MAX_EDGES) begin
                  drop_flag_next = 1'b1;
                end else begin
                  edge_req.wr_en  = 1'b1;
                  edge_total_next = edge_total + CB'(1);
                  if (edge_top > node_span) begin
                    node_span_next = edge_top;
                  end
                end
              end
            end
            sssp_pkg::CMD_CLEAR: begin
              edge_total_next = '0;
              node_span_next  = '0;
              drop_flag_next  = 1'b0;
            end
            sssp_pkg::CMD_QUERY: begin
              if (SB'(request.query_source) < query_span &&
                  SB'(request.query_destination) < query_span) begin
                dist_req.clear = 1'b1;
                dist_req.wr_en = 1'b1;
                span_next      = query_span;
                dst_next       = NB'(request.query_destination);
                scan_idx_next  = '0;
                pick_d_next    = sssp_pkg::DIST_INF;
                state_next     = sssp_pkg::ST_SCAN;
              end else begin
                response_next.distance      = sssp_pkg::DIST_INF;
                response_next.reachable     = 1'b0;
                response_next.edges_dropped = drop_flag;
                done_next                   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      sssp_pkg::ST_SCAN: begin
        if (scan_issue) begin
          scan_idx_next = scan_idx + SB'(1);
          scan_v_next   = 1'b1;
        end
        if (scan_v && !dist_rsp.settled && dist_rsp.path_dist < pick_d) begin
          pick_d_next = dist_rsp.path_dist;
          pick_next   = scan_idx_d;
        end
        if (!scan_issue && !scan_v) begin
          if (pick_d != sssp_pkg::DIST_INF) begin
            dist_req.settle_en = 1'b1;
            edge_idx_next      = '0;
            state_next         = sssp_pkg::ST_RELAX;
          end else begin
            state_next = sssp_pkg::ST_FETCH;
          end
        end
      end

      sssp_pkg::ST_RELAX: begin
        if (edge_issue) begin
          edge_idx_next = edge_idx + CB'(1);
          e_v1_next     = 1'b1;
        end
        if (e_v1 && edge_rd.tail == pick && SB'(edge_rd.head) < span) begin
          dist_req.rd_addr = edge_rd.head;
          e_v2_next        = 1'b1;
          head_d_next      = edge_rd.head;
          w_d_next         = edge_rd.weight;
        end
        if (e_v2 && new_dist < cur_dist) begin
          dist_req.wr_en   = 1'b1;
          dist_req.wr_addr = head_d;
          dist_req.wr_data = new_dist;
          fwd_v_next       = 1'b1;
          fwd_addr_next    = head_d;
          fwd_val_next     = new_dist;
        end
        if (!edge_issue && !e_v1 && !e_v2) begin
          scan_idx_next = '0;
          pick_d_next   = sssp_pkg::DIST_INF;
          state_next    = sssp_pkg::ST_SCAN;
        end
      end

      sssp_pkg::ST_FETCH: begin
        dist_req.rd_addr = dst;
        state_next       = sssp_pkg::ST_REPLY;
      end

      sssp_pkg::ST_REPLY: begin
        response_next.distance      = dist_rsp.path_dist;
        response_next.reachable     = dist_rsp.path_dist != sssp_pkg::DIST_INF;
        response_next.edges_dropped = drop_flag;
        done_next                   = 1'b1;
        state_next                  = sssp_pkg::ST_IDLE;
      end

      default: begin
        state_next = sssp_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = state != sssp_pkg::ST_IDLE;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == sssp_pkg::ST_IDLE)
    else $error("result strobe outside the idle state");

  a_reach_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (response.reachable == (response.distance != sssp_pkg::DIST_INF)))
    else $error("reachable flag disagrees with distance code");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(edge_total) <= sssp_pkg::MAX_EDGES)
    else $error("edge count beyond store depth");

  a_relax_drain: assert property (@(posedge clk) disable iff (rst)
    (e_v1 || e_v2) |-> state == sssp_pkg::ST_RELAX)
    else $error("relax pipeline beat outside relax phase");

  a_scan_drain: assert property (@(posedge clk) disable iff (rst)
    scan_v |-> state == sssp_pkg::ST_SCAN)
    else $error("scan beat outside scan phase");

endmodule

// ----- design/single_source_shortest_path_core.sv -----
// Single-source shortest path core: an add-edge or clear beat is accepted with busy kept
// low. A query whose source or destination lies beyond the node span answers in
// the next cycle with busy low. Any other query holds busy high while it runs. For each
// node reached from the source it scans the span for the closest open node over the
// distance memory's single read port, then passes over the edge store, one entry per
// cycle; the last scan, which finds no open node, is followed by a read of the
// destination and then the reply. The result is shown on response for exactly one cycle
// with done high and is not held, so the receiver must take it then. Top level;
// instantiates sssp_engine, sssp_edge_store and sssp_dist_mem.
module single_source_shortest_path_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  sssp_pkg::request_t  request,
  output logic                busy,
  output sssp_pkg::response_t response,
  output logic                done
);

  sssp_pkg::edge_req_t edge_req;
  sssp_pkg::edge_t     edge_rd;
  sssp_pkg::dist_req_t dist_req;
  sssp_pkg::dist_rsp_t dist_rsp;

  sssp_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .response (response),
    .done     (done),
    .edge_req (edge_req),
    .edge_rd  (edge_rd),
    .dist_req (dist_req),
    .dist_rsp (dist_rsp)
  );

  sssp_edge_store u_edge_store (
    .clk     (clk),
    .req     (edge_req),
    .rd_data (edge_rd)
  );

  sssp_dist_mem u_dist_mem (
    .clk (clk),
    .rst (rst),
    .req (dist_req),
    .rsp (dist_rsp)
  );

endmodule

// ----- bench/tb_single_source_shortest_path_core.sv -----
// Self-checking bench for single_source_shortest_path_core: drives edge, clear and query
// beats and checks every answer against a distance tracker kept inside the bench.
// Depends on design/sssp_pkg.sv and the core's RTL.
module tb_single_source_shortest_path_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         STALL_LIMIT  = 400000;
  localparam int         RANDOM_BEATS = 1930;

  // Tracks the edge list, node span and drop flag, and works out the answer of each query.
  class distance_tracker;
    logic [sssp_pkg::NODE_BITS-1:0]   tails[sssp_pkg::MAX_EDGES];
    logic [sssp_pkg::NODE_BITS-1:0]   heads[sssp_pkg::MAX_EDGES];
    logic [sssp_pkg::WEIGHT_BITS-1:0] weights[sssp_pkg::MAX_EDGES];
    int unsigned                      stored;
    int unsigned                      span;
    bit                               lost;
    sssp_pkg::response_t              owed_answers[$];
    int unsigned                      bad_answers;

    function void log_request(sssp_pkg::request_t beat);
      logic [sssp_pkg::DIST_BITS-1:0] best[sssp_pkg::MAX_NODES];
      bit                             settled[sssp_pkg::MAX_NODES];
      logic [sssp_pkg::DIST_BITS-1:0] pick_dist;
      logic [sssp_pkg::DIST_BITS:0]   reach_sum;
      int unsigned                    limit;
      int unsigned                    pick;
      sssp_pkg::response_t            answer;
      case (beat.command)
        sssp_pkg::CMD_ADD: begin
          if (beat.edge_from < sssp_pkg::MAX_NODES && beat.edge_to < sssp_pkg::MAX_NODES) begin
            if (stored == sssp_pkg::MAX_EDGES) begin
              lost = 1'b1;
            end else begin
              tails[stored]   = beat.edge_from;
              heads[stored]   = beat.edge_to;
              weights[stored] = beat.edge_weight[sssp_pkg::WEIGHT_BITS-1:0];
              stored++;
              limit = ((beat.edge_from > beat.edge_to) ? beat.edge_from : beat.edge_to) + 1;
              if (limit > span) span = limit;
            end
          end
        end
        sssp_pkg::CMD_CLEAR: begin
          stored = 0;
          span   = 0;
          lost   = 1'b0;
        end
        sssp_pkg::CMD_QUERY: begin
          limit = (span == 0) ? 1 : span;
          answer.edges_dropped = lost;
          if (beat.query_source >= limit || beat.query_destination >= limit) begin
            answer.distance = sssp_pkg::DIST_INF;
          end else begin
            for (int n = 0; n < limit; n++) begin
              best[n]    = sssp_pkg::DIST_INF;
              settled[n] = 1'b0;
            end
            best[beat.query_source] = '0;
            // Settle the closest open node each round; lowest id wins a tie.
            do begin
              pick      = limit;
              pick_dist = sssp_pkg::DIST_INF;
              for (int n = 0; n < limit; n++) begin
                if (!settled[n] && best[n] < pick_dist) begin
                  pick_dist = best[n];
                  pick      = n;
                end
              end
              if (pick < limit) begin
                settled[pick] = 1'b1;
                for (int k = 0; k < stored; k++) begin
                  if (tails[k] == pick && heads[k] < limit) begin
                    reach_sum = pick_dist + weights[k];
                    if (reach_sum > sssp_pkg::DIST_CAP) reach_sum = sssp_pkg::DIST_CAP;
                    if (reach_sum[sssp_pkg::DIST_BITS-1:0] < best[heads[k]])
                      best[heads[k]] = reach_sum[sssp_pkg::DIST_BITS-1:0];
                  end
                end
              end
            end while (pick < limit);
            answer.distance = best[beat.query_destination];
          end
          answer.reachable = (answer.distance != sssp_pkg::DIST_INF);
          owed_answers = {owed_answers, answer};
        end
        default: ;
      endcase
    endfunction

    function void check_answer(sssp_pkg::response_t got);
      sssp_pkg::response_t want;
      if (owed_answers.size() == 0) begin
        if (bad_answers < 10)
          $display("unexpected answer: distance %0d reachable %0b dropped %0b",
                   got.distance, got.reachable, got.edges_dropped);
        bad_answers++;
      end else begin
        want = owed_answers.pop_front();
        if (got.distance !== want.distance || got.reachable !== want.reachable ||
            got.edges_dropped !== want.edges_dropped) begin
          if (bad_answers < 10)
            $display("answer mismatch (distance reachable dropped): expected %0d %0b %0b, %s",
                     want.distance, want.reachable, want.edges_dropped,
                     $sformatf("got %0d %0b %0b",
                               got.distance, got.reachable, got.edges_dropped));
          bad_answers++;
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  sssp_pkg::request_t  request = '0;
  logic                busy;
  sssp_pkg::response_t response;
  logic                done;

  distance_tracker tracker;
  bit              tight;
  int unsigned     beats_sent;
  int unsigned     idle_cycles;

  single_source_shortest_path_core DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .response (response),
    .done     (done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fields that the command does not use carry random values.
  task automatic issue(input logic [1:0] cmd, input logic [7:0] a, input logic [7:0] b,
                       input logic [15:0] w);
    sssp_pkg::request_t beat;
    logic [63:0]        noise;
    int unsigned        wait_cycles;
    noise = {$urandom, $urandom};
    beat = noise[$bits(sssp_pkg::request_t)-1:0];
    beat.command = cmd;
    if (cmd == sssp_pkg::CMD_ADD) begin
      beat.edge_from   = a;
      beat.edge_to     = b;
      beat.edge_weight = w;
    end else if (cmd == sssp_pkg::CMD_QUERY) begin
      beat.query_source      = a;
      beat.query_destination = b;
    end
    wait_cycles = tight ? 0 : $urandom_range(0, 11);
    if (wait_cycles != 0) begin
      start <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    start   <= 1'b1;
    request <= beat;
    do @(posedge clk); while (busy);
    tracker.log_request(beat);
    if (cmd != CMD_UNUSED) beats_sent++;
  endtask

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(1, 15));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_node(int unsigned nodes);
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, nodes - 1));
    return 8'($urandom);
  endfunction

  always @(posedge clk) begin
    if (!rst && done) tracker.check_answer(response);
  end

  // Ends the run if neither side moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[single_source_shortest_path_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned base;
    int unsigned nodes;
    int unsigned adds_left;
    int unsigned asks_left;
    int unsigned roll;
    bit          wide;
    tracker = new;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty graph: node 0 reaches itself, anything else lies beyond the span.
    issue(sssp_pkg::CMD_QUERY, 8'd0, 8'd0, 16'd0);
    issue(sssp_pkg::CMD_QUERY, 8'd0, 8'd1, 16'd0);
    issue(CMD_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom));
    issue(sssp_pkg::CMD_ADD, 8'd0, 8'd1, 16'd5);
    issue(sssp_pkg::CMD_ADD, 8'd1, 8'd2, 16'd0);
    issue(sssp_pkg::CMD_ADD, 8'd0, 8'd2, 16'hFFFF);
    issue(sssp_pkg::CMD_ADD, 8'd1, 8'd1, 16'd3);
    issue(sssp_pkg::CMD_ADD, 8'd2, 8'd3, 16'hFFFF);
    issue(sssp_pkg::CMD_QUERY, 8'd0, 8'd2, 16'd0);
    issue(sssp_pkg::CMD_QUERY, 8'd0, 8'd3, 16'd0);
    issue(sssp_pkg::CMD_QUERY, 8'd3, 8'd0, 16'd0);
    issue(sssp_pkg::CMD_QUERY, 8'd2, 8'd2, 16'd0);
    issue(sssp_pkg::CMD_QUERY, 8'd0, 8'd200, 16'd0);
    issue(sssp_pkg::CMD_QUERY, 8'd255, 8'd0, 16'd0);
    // Pushing the span to the top node id makes the next queries the slowest ones.
    issue(sssp_pkg::CMD_ADD, 8'hAA, 8'h55, 16'h5555);
    issue(sssp_pkg::CMD_ADD, 8'h55, 8'hFF, 16'hAAAA);
    issue(sssp_pkg::CMD_QUERY, 8'hAA, 8'hFF, 16'd0);
    issue(sssp_pkg::CMD_QUERY, 8'hFF, 8'h00, 16'd0);
    issue(sssp_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom));
    issue(sssp_pkg::CMD_QUERY, 8'd0, 8'd0, 16'd0);
    issue(sssp_pkg::CMD_QUERY, 8'd1, 8'd0, 16'd0);

    // Random graphs: mostly a handful of nodes, now and then one spread over 17 to 256 ids.
    base = beats_sent;
    while (beats_sent - base < RANDOM_BEATS) begin
      tight = ($urandom_range(0, 3) == 0);
      issue(sssp_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom));
      wide      = ($urandom_range(0, 19) == 0);
      nodes     = wide ? $urandom_range(17, 256) : $urandom_range(2, 16);
      adds_left = $urandom_range(0, wide ? 24 : 3 * nodes);
      asks_left = wide ? $urandom_range(1, 2) : $urandom_range(3, 12);
      while (adds_left + asks_left > 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          issue(CMD_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom));
        end else if (roll < 5) begin
          issue(sssp_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom));
        end else if (adds_left > 0 && (asks_left == 0 || $urandom_range(0, 2) != 0)) begin
          issue(sssp_pkg::CMD_ADD, 8'($urandom_range(0, nodes - 1)),
                8'($urandom_range(0, nodes - 1)), pick_weight());
          adds_left--;
        end else begin
          issue(sssp_pkg::CMD_QUERY, pick_node(nodes), pick_node(nodes), 16'd0);
          asks_left--;
        end
      end
    end
    start <= 1'b0;

    while (tracker.owed_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.bad_answers == 0 && tracker.owed_answers.size() == 0)
      $display("[single_source_shortest_path_core] OK");
    else
      $display("[single_source_shortest_path_core] ERROR");
    $finish;
  end

endmodule
